FILE: rtl/rc_channel_frame_encoder_defines.svh
`ifndef RC_CHANNEL_FRAME_ENCODER_DEFINES_SVH
`define RC_CHANNEL_FRAME_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RCFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RCFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rcfe_pkg.sv
`timescale 1ns / 1ps
package rcfe_pkg;

	localparam int NUM_AXES   = 7;
	localparam int CHAN_W     = 11;
	localparam int CRSF_CHANS = 16;
	localparam int IBUS_CHANS = 14;
	localparam int POS_W      = 5;

	localparam int CRSF_FRAME_LEN = 26;
	localparam int IBUS_FRAME_LEN = 32;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [POS_W-1:0]  pos_t;

	typedef enum logic {
		MODE_CRSF = 1'b0,
		MODE_IBUS = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [NUM_AXES-1:0][CHAN_W-1:0] ch;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	localparam chan_t IN_MIN      = 11'd1000;
	localparam chan_t IN_MAX      = 11'd2000;
	localparam chan_t CRSF_OFFSET = 11'd172;
	localparam chan_t CRSF_UNUSED = 11'd992;
	localparam logic [15:0] IBUS_UNUSED = 16'd1500;

	// floor(t * 1639 / 1000) == (t * SCALE_MULT) >> SCALE_SHIFT for t <= 1000
	localparam int          SCALE_SHIFT = 20;
	localparam logic [20:0] SCALE_MULT  = 21'd1718617;
	localparam int          PROD_W      = 31;

	localparam logic [7:0] CRC_POLY   = 8'hD5;
	localparam logic [7:0] CRSF_SYNC  = 8'hC8;
	localparam logic [7:0] CRSF_LEN   = 8'd24;
	localparam logic [7:0] CRSF_TYPE  = 8'h16;
	localparam logic [7:0] IBUS_HDR0  = 8'h20;
	localparam logic [7:0] IBUS_HDR1  = 8'h40;

	localparam pos_t CRSF_POS_SYNC  = 5'd0;
	localparam pos_t CRSF_POS_LEN   = 5'd1;
	localparam pos_t CRSF_POS_TYPE  = 5'd2;
	localparam pos_t CRSF_PAY_FIRST = 5'd3;
	localparam pos_t CRSF_PAY_LAST  = 5'd24;
	localparam pos_t CRSF_POS_CRC   = 5'd25;
	localparam pos_t IBUS_POS_HDR0  = 5'd0;
	localparam pos_t IBUS_POS_HDR1  = 5'd1;
	localparam pos_t IBUS_PAY_FIRST = 5'd2;
	localparam pos_t IBUS_PAY_LAST  = 5'd29;
	localparam pos_t IBUS_POS_CHK_LO = 5'd30;
	localparam pos_t IBUS_POS_CHK_HI = 5'd31;

endpackage

FILE: rtl/rcfe_front.sv
`timescale 1ns / 1ps
module rcfe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rcfe_pkg::chan_t      roll,
	input  rcfe_pkg::chan_t      pitch,
	input  rcfe_pkg::chan_t      yaw,
	input  rcfe_pkg::chan_t      throttle,
	input  rcfe_pkg::chan_t      switch_one,
	input  rcfe_pkg::chan_t      switch_two,
	input  rcfe_pkg::chan_t      switch_three,
	input  rcfe_pkg::mode_t      mode,
	input  rcfe_pkg::fifo_stat_t q_stat,
	output logic                 push,
	output rcfe_pkg::desc_t      push_data
);
	import rcfe_pkg::*;

	localparam logic [3:0] STEP_LAST = 4'(NUM_AXES);
	localparam logic [3:0] STEP_DONE = 4'(NUM_AXES + 1);

	function automatic chan_t clamp_in(input chan_t v);
		if (v < IN_MIN) return IN_MIN;
		if (v > IN_MAX) return IN_MAX;
		return v;
	endfunction

	logic                      busy_q;
	logic [3:0]                cnt_q;
	mode_t                     mode_q;
	chan_t [NUM_AXES-1:0]      in_q;
	chan_t [NUM_AXES-1:0]      ch_q;
	logic [PROD_W-1:0]         prod_s1;
	chan_t                     raw_s1;
	logic [9:0]                t;
	chan_t                     scaled;
	chan_t                     ch_val;
	logic                      accept;
	logic                      done;
	logic                      mul_en;
	logic                      shift_en;

	assign done     = busy_q && (cnt_q == STEP_DONE);
	assign push     = done && !q_stat.full;
	assign in_stall = busy_q && !push;
	assign accept   = in_valid && !in_stall;
	assign mul_en   = busy_q && (cnt_q < STEP_LAST);
	assign shift_en = busy_q && (cnt_q >= 4'd1) && (cnt_q <= STEP_LAST);

	assign t      = 10'(in_q[0] - IN_MIN);
	assign scaled = 11'(prod_s1 >> SCALE_SHIFT) + CRSF_OFFSET;
	assign ch_val = (mode_q == MODE_CRSF) ? scaled : raw_s1;

	always_comb begin
		push_data.mode = mode_q;
		push_data.ch   = ch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (push) begin
			busy_q <= 1'b0;
		end else if (busy_q && (cnt_q != STEP_DONE)) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	// channel order: roll, pitch, throttle, yaw, switches
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			in_q[0] <= clamp_in(roll);
			in_q[1] <= clamp_in(pitch);
			in_q[2] <= clamp_in(throttle);
			in_q[3] <= clamp_in(yaw);
			in_q[4] <= clamp_in(switch_one);
			in_q[5] <= clamp_in(switch_two);
			in_q[6] <= clamp_in(switch_three);
		end else if (mul_en) begin
			for (int i = 0; i < NUM_AXES - 1; i++) begin
				in_q[i] <= in_q[i+1];
			end
		end
		if (mul_en) begin
			prod_s1 <= PROD_W'(t) * PROD_W'(SCALE_MULT);
			raw_s1  <= in_q[0];
		end
		if (shift_en) begin
			for (int i = 0; i < NUM_AXES - 1; i++) begin
				ch_q[i] <= ch_q[i+1];
			end
			ch_q[NUM_AXES-1] <= ch_val;
		end
	end

endmodule

FILE: rtl/rcfe_fifo.sv
`timescale 1ns / 1ps
module rcfe_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rcfe_pkg::desc_t      push_data,
	input  logic                 pop,
	output rcfe_pkg::desc_t      pop_data,
	output rcfe_pkg::fifo_stat_t stat
);
	import rcfe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	desc_t         entry_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_FULL);
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/rcfe_back.sv
`timescale 1ns / 1ps
module rcfe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rcfe_pkg::fifo_stat_t q_stat,
	output logic                 pop,
	input  rcfe_pkg::desc_t      pop_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           frame_byte,
	output logic                 last_byte
);
	import rcfe_pkg::*;

	localparam int CRSF_PAY_BYTES = (CRSF_CHANS * CHAN_W) / 8;
	localparam int IBUS_PAY_BYTES = IBUS_CHANS * 2;

	function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	logic        active_q;
	pos_t        pos_q;
	desc_t       desc_q;
	logic [7:0]  crc_q;
	logic [15:0] sum_q;
	logic        out_valid_q;
	logic [7:0]  frame_byte_q;
	logic        last_byte_q;

	logic [CRSF_PAY_BYTES-1:0][7:0]         crsf_bytes;
	logic [CRSF_CHANS-1:0][CHAN_W-1:0]      crsf_chans;
	logic [IBUS_PAY_BYTES-1:0][7:0]         ibus_bytes;
	logic [IBUS_CHANS-1:0][15:0]            ibus_words;
	logic [4:0]  crsf_idx;
	logic [4:0]  ibus_idx;
	logic [15:0] chk;
	logic [7:0]  cur_byte;
	logic        cur_last;
	logic        adv;

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;

	assign adv      = active_q && (!out_valid_q || !out_stall);
	assign cur_last = (desc_q.mode == MODE_CRSF) ? (pos_q == CRSF_POS_CRC)
		: (pos_q == IBUS_POS_CHK_HI);
	assign pop      = !q_stat.empty && (!active_q || (adv && cur_last));

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			crsf_chans[i] = desc_q.ch[i];
			ibus_words[i] = {5'b0, desc_q.ch[i]};
		end
		for (int i = NUM_AXES; i < CRSF_CHANS; i++) begin
			crsf_chans[i] = CRSF_UNUSED;
		end
		for (int i = NUM_AXES; i < IBUS_CHANS; i++) begin
			ibus_words[i] = IBUS_UNUSED;
		end
	end

	assign crsf_bytes = crsf_chans;
	assign ibus_bytes = ibus_words;
	assign crsf_idx   = pos_q - CRSF_PAY_FIRST;
	assign ibus_idx   = pos_q - IBUS_PAY_FIRST;
	assign chk        = ~sum_q;

	always_comb begin
		cur_byte = '0;
		if (desc_q.mode == MODE_CRSF) begin
			case (pos_q)
				CRSF_POS_SYNC: cur_byte = CRSF_SYNC;
				CRSF_POS_LEN:  cur_byte = CRSF_LEN;
				CRSF_POS_TYPE: cur_byte = CRSF_TYPE;
				CRSF_POS_CRC:  cur_byte = crc_q;
				default: begin
					if (pos_q inside {[CRSF_PAY_FIRST:CRSF_PAY_LAST]}) begin
						cur_byte = crsf_bytes[crsf_idx];
					end
				end
			endcase
		end else begin
			case (pos_q)
				IBUS_POS_HDR0:   cur_byte = IBUS_HDR0;
				IBUS_POS_HDR1:   cur_byte = IBUS_HDR1;
				IBUS_POS_CHK_LO: cur_byte = chk[7:0];
				IBUS_POS_CHK_HI: cur_byte = chk[15:8];
				default: begin
					if (pos_q inside {[IBUS_PAY_FIRST:IBUS_PAY_LAST]}) begin
						cur_byte = ibus_bytes[ibus_idx];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				active_q <= 1'b1;
				pos_q    <= '0;
			end else if (adv) begin
				pos_q <= pos_q + POS_W'(1);
				if (cur_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_byte_q <= cur_byte;
			last_byte_q  <= cur_last;
			if ((desc_q.mode == MODE_CRSF) && (pos_q inside {[CRSF_POS_TYPE:CRSF_PAY_LAST]})) begin
				crc_q <= crc_next(crc_q, cur_byte);
			end
			if ((desc_q.mode == MODE_IBUS) && (pos_q <= IBUS_PAY_LAST)) begin
				sum_q <= sum_q + {8'b0, cur_byte};
			end
		end
		if (pop) begin
			desc_q <= pop_data;
			crc_q  <= '0;
			sum_q  <= '0;
		end
	end

endmodule

FILE: rtl/rc_channel_frame_encoder.sv
`timescale 1ns / 1ps
// Radio-control channel frame encoder. One transaction on the input side carries seven
// stick and switch values (saturated to 1000..2000) and becomes one frame on the output
// side, one byte per transaction with last_byte set on the final byte: 26 bytes in CRSF
// mode (protocol_mode 0, channels rescaled to 172..1811, CRC-8 poly 0xD5 at the end) or
// 32 bytes in IBUS mode (protocol_mode 1, 16-bit checksum at the end). The front end
// pushes the seven channels through one shared multiply-and-shift scaler, one channel
// a cycle; a queue of QUEUE_DEPTH frames follows. The output serializer sends one byte
// a cycle while out_stall is low, so with no stalls and a non-empty queue the block
// sends frames back to back with no gap.
// protocol_mode is sampled when a frame is accepted; change it only while idle.
module rc_channel_frame_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  rcfe_pkg::chan_t     roll,
	input  rcfe_pkg::chan_t     pitch,
	input  rcfe_pkg::chan_t     yaw,
	input  rcfe_pkg::chan_t     throttle,
	input  rcfe_pkg::chan_t     switch_one,
	input  rcfe_pkg::chan_t     switch_two,
	input  rcfe_pkg::chan_t     switch_three,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          frame_byte,
	output logic                last_byte
);
	import rcfe_pkg::*;

	mode_t      protocol_mode_q;
	logic       push;
	desc_t      push_data;
	logic       pop;
	desc_t      pop_data;
	fifo_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_mode_q <= MODE_CRSF;
		end else if (cfg_we) begin
			protocol_mode_q <= mode_t'(cfg_wdata);
		end
	end

	rcfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.roll         (roll),
		.pitch        (pitch),
		.yaw          (yaw),
		.throttle     (throttle),
		.switch_one   (switch_one),
		.switch_two   (switch_two),
		.switch_three (switch_three),
		.mode         (protocol_mode_q),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	rcfe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	rcfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop        (pop),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

FILE: rtl/rcfe_checker.sv
`timescale 1ns / 1ps
`include "rc_channel_frame_encoder_defines.svh"
module rcfe_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input logic [7:0]      frame_byte,
	input logic            last_byte
);
	import rcfe_pkg::*;

	localparam pos_t CRSF_LAST_POS = POS_W'(CRSF_FRAME_LEN - 1);
	localparam pos_t IBUS_LAST_POS = POS_W'(IBUS_FRAME_LEN - 1);

	logic out_xfer;
	logic start_q;
	pos_t cnt_q;

	assign out_xfer = out_valid && !out_stall;

	// byte position within the current outgoing frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			cnt_q   <= '0;
		end else if (out_xfer) begin
			start_q <= last_byte;
			cnt_q   <= last_byte ? '0 : cnt_q + POS_W'(1);
		end
	end

	`RCFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(frame_byte) && $stable(last_byte), "stalled output transaction changed")
	`RCFE_ASSERT_NOW(a_frame_sync, out_xfer && start_q, frame_byte == CRSF_SYNC || frame_byte == IBUS_HDR0, "frame does not open with a sync byte")
	`RCFE_ASSERT_NOW(a_frame_len, out_xfer && last_byte, cnt_q == CRSF_LAST_POS || cnt_q == IBUS_LAST_POS, "frame length is neither 26 nor 32 bytes")
	`RCFE_ASSERT_NOW(a_frame_overrun, out_xfer && !last_byte, cnt_q != IBUS_LAST_POS, "frame runs past 32 bytes")

endmodule

bind rc_channel_frame_encoder rcfe_checker u_rcfe_checker (.*);
